FILE: hw/rtl/recursive_mutex_fifo_handoff_core_defines.svh
// assertion helpers shared by the mutex core
`ifndef RECURSIVE_MUTEX_FIFO_HANDOFF_CORE_DEFINES_SVH
`define RECURSIVE_MUTEX_FIFO_HANDOFF_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RMFH_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rmfh assertion failed");
`define RMFH_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rmfh assertion failed");
`else
`define RMFH_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define RMFH_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

FILE: hw/rtl/rmfh_pkg.sv
package rmfh_pkg;

   localparam int ID_W            = 8;
   localparam int OP_W            = 2;
   localparam int ST_W            = 3;
   localparam int ERR_W           = 2;
   localparam int HOLD_W          = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_NEST_DEF    = 255;

   typedef enum logic [OP_W-1:0] {
      OP_LOCK   = 2'd0,
      OP_TRY    = 2'd1,
      OP_UNLOCK = 2'd2,
      OP_RSVD   = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_GRANTED = 3'd0,
      ST_QUEUED  = 3'd1,
      ST_REFUSED = 3'd2,
      ST_FREED   = 3'd3,
      ST_HANDED  = 3'd4,
      ST_NESTREL = 3'd5,
      ST_ERROR   = 3'd6
   } status_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_SAT   = 2'd2,
      ERR_OWNER = 2'd3
   } err_type;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   id;
   } req_beat_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

FILE: hw/rtl/rmfh_req_if.sv
interface rmfh_req_if;
   logic                        valid;
   logic                        ready;
   logic [rmfh_pkg::OP_W-1:0]   opcode;
   logic [rmfh_pkg::ID_W-1:0]   requester_id;

   modport source (output valid, output opcode, output requester_id, input ready);
   modport sink (input valid, input opcode, input requester_id, output ready);
endinterface

FILE: hw/rtl/rmfh_rsp_if.sv
interface rmfh_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rmfh_pkg::ST_W-1:0]     status;
   logic [rmfh_pkg::ERR_W-1:0]    error_code;
   logic                          wake_valid;
   logic [rmfh_pkg::ID_W-1:0]     wake_id;
   logic [rmfh_pkg::HOLD_W-1:0]   hold_count;

   modport source (output valid, output status, output error_code, output wake_valid,
                   output wake_id, output hold_count, input ready);
   modport sink (input valid, input status, input error_code, input wake_valid,
                 input wake_id, input hold_count, output ready);
endinterface

FILE: hw/rtl/recursive_mutex_fifo_handoff_core.sv
// a request beat is registered in the input stage, then its response in the lock engine
// one request per cycle unless rsp stalls; each sees the state left by the one before
// the owner, nest count and queue pointers update in the same cycle the response registers
// reset clears ownership, nest count, queue pointers and recursive mode at once
// queue entries hold no reset value; only occupied slots are ever read
module recursive_mutex_fifo_handoff_core #(
   parameter int QUEUE_DEPTH = rmfh_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_NEST    = rmfh_pkg::MAX_NEST_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_wdata,
   rmfh_req_if.sink      req_ch,
   rmfh_rsp_if.source    rsp_ch
);

   logic                        beat_valid;
   rmfh_pkg::req_beat_type      beat;
   logic                        advance;
   rmfh_pkg::q_ctrl_type        q_ctrl;
   rmfh_pkg::q_stat_type        q_stat;
   logic [rmfh_pkg::ID_W-1:0]   q_head_id;

   rmfh_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   rmfh_wait_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_wait_queue (
      .clock   (clock),
      .reset   (reset),
      .q_ctrl  (q_ctrl),
      .push_id (beat.id),
      .q_stat  (q_stat),
      .head_id (q_head_id)
   );

   rmfh_lock_engine #(
      .MAX_NEST (MAX_NEST)
   ) u_lock_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .beat_valid (beat_valid),
      .beat       (beat),
      .advance    (advance),
      .q_ctrl     (q_ctrl),
      .q_stat     (q_stat),
      .q_head_id  (q_head_id),
      .rsp_ch     (rsp_ch)
   );

endmodule

FILE: hw/rtl/rmfh_in_stage.sv
module rmfh_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   rmfh_req_if.sink               req_ch,
   input  logic                   advance,
   output logic                   beat_valid,
   output rmfh_pkg::req_beat_type beat
);

   logic                   valid_ff;
   logic                   valid_in;
   rmfh_pkg::req_beat_type beat_ff;
   logic                   take;

   // the held beat leaves in the same cycle a new one may arrive
   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff.op <= rmfh_pkg::op_type'(req_ch.opcode);
         beat_ff.id <= req_ch.requester_id;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

FILE: hw/rtl/rmfh_wait_queue.sv
`include "recursive_mutex_fifo_handoff_core_defines.svh"

module rmfh_wait_queue #(
   parameter int QUEUE_DEPTH = rmfh_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rmfh_pkg::q_ctrl_type        q_ctrl,
   input  logic [rmfh_pkg::ID_W-1:0]   push_id,
   output rmfh_pkg::q_stat_type        q_stat,
   output logic [rmfh_pkg::ID_W-1:0]   head_id
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   logic [rmfh_pkg::ID_W-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]          head_ff;
   logic [PTR_W-1:0]          head_in;
   logic [PTR_W-1:0]          tail_ff;
   logic [PTR_W-1:0]          tail_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (q_ctrl.push) begin
         tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (q_ctrl.pop) begin
         head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ctrl.push) begin
         entries_ff[tail_ff] <= push_id;
      end
   end

   assign head_id      = entries_ff[head_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == FULL_CNT);

   `RMFH_ASSERT_IMPLY(a_no_push_full, clock, reset, q_ctrl.push, !q_stat.full)
   `RMFH_ASSERT_IMPLY(a_no_pop_empty, clock, reset, q_ctrl.pop, !q_stat.empty)
   `RMFH_ASSERT_NEXT(a_push_fills, clock, reset, q_ctrl.push, !q_stat.empty)

endmodule

FILE: hw/rtl/rmfh_lock_engine.sv
`include "recursive_mutex_fifo_handoff_core_defines.svh"

module rmfh_lock_engine #(
   parameter int MAX_NEST = rmfh_pkg::MAX_NEST_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   input  logic                        beat_valid,
   input  rmfh_pkg::req_beat_type      beat,
   output logic                        advance,
   output rmfh_pkg::q_ctrl_type        q_ctrl,
   input  rmfh_pkg::q_stat_type        q_stat,
   input  logic [rmfh_pkg::ID_W-1:0]   q_head_id,
   rmfh_rsp_if.source                  rsp_ch
);

   localparam int NEST_W = $clog2(MAX_NEST + 1);
   localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NEST);
   localparam logic [NEST_W-1:0] NEST_ONE = NEST_W'(1);

   logic                         recursive_ff;
   logic [NEST_W-1:0]            nest_ff;
   logic [NEST_W-1:0]            nest_in;
   logic [rmfh_pkg::ID_W-1:0]    owner_ff;
   logic [rmfh_pkg::ID_W-1:0]    owner_in;

   logic                         rsp_valid_ff;
   rmfh_pkg::status_type         status_ff;
   rmfh_pkg::status_type         status_in;
   rmfh_pkg::err_type            err_ff;
   rmfh_pkg::err_type            err_in;
   logic                         wake_ff;
   logic                         wake_in;
   logic [rmfh_pkg::ID_W-1:0]    wake_id_ff;
   logic [rmfh_pkg::ID_W-1:0]    wake_id_in;
   logic [rmfh_pkg::HOLD_W-1:0]  hold_ff;
   logic [NEST_W+rmfh_pkg::HOLD_W-1:0] hold_wide;

   logic                         is_free;
   logic                         can_nest;
   logic                         is_owner;

   assign advance  = beat_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign is_free  = (nest_ff == '0);
   assign is_owner = (owner_ff == beat.id);
   assign can_nest = recursive_ff && is_owner;

   always_comb begin
      nest_in    = nest_ff;
      owner_in   = owner_ff;
      status_in  = rmfh_pkg::ST_REFUSED;
      err_in     = rmfh_pkg::ERR_NONE;
      wake_in    = 1'b0;
      wake_id_in = '0;
      q_ctrl     = '0;
      unique case (beat.op)
         rmfh_pkg::OP_LOCK, rmfh_pkg::OP_TRY: begin
            if (is_free) begin
               nest_in   = NEST_ONE;
               owner_in  = beat.id;
               status_in = rmfh_pkg::ST_GRANTED;
            end else if (can_nest) begin
               if (nest_ff >= NEST_MAX) begin
                  status_in = rmfh_pkg::ST_ERROR;
                  err_in    = rmfh_pkg::ERR_SAT;
               end else begin
                  nest_in   = nest_ff + 1'b1;
                  status_in = rmfh_pkg::ST_GRANTED;
               end
            end else if (beat.op == rmfh_pkg::OP_LOCK) begin
               if (q_stat.full) begin
                  status_in = rmfh_pkg::ST_ERROR;
                  err_in    = rmfh_pkg::ERR_FULL;
               end else begin
                  q_ctrl.push = beat_valid && advance;
                  status_in   = rmfh_pkg::ST_QUEUED;
               end
            end
         end
         rmfh_pkg::OP_UNLOCK: begin
            if (is_free || !is_owner) begin
               status_in = rmfh_pkg::ST_ERROR;
               err_in    = rmfh_pkg::ERR_OWNER;
            end else if (nest_ff != NEST_ONE) begin
               nest_in   = nest_ff - 1'b1;
               status_in = rmfh_pkg::ST_NESTREL;
            end else if (q_stat.empty) begin
               nest_in   = '0;
               owner_in  = '0;
               status_in = rmfh_pkg::ST_FREED;
            end else begin
               // last release with waiters: the queue head takes over at depth one
               q_ctrl.pop = beat_valid && advance;
               nest_in    = NEST_ONE;
               owner_in   = q_head_id;
               status_in  = rmfh_pkg::ST_HANDED;
               wake_in    = 1'b1;
               wake_id_in = q_head_id;
            end
         end
         default: begin
            status_in = rmfh_pkg::ST_REFUSED;
         end
      endcase
   end

   assign hold_wide = {{rmfh_pkg::HOLD_W{1'b0}}, nest_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         recursive_ff <= 1'b0;
         nest_ff      <= '0;
         owner_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            recursive_ff <= csr_wdata;
         end
         if (advance) begin
            nest_ff      <= nest_in;
            owner_ff     <= owner_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff  <= status_in;
         err_ff     <= err_in;
         wake_ff    <= wake_in;
         wake_id_ff <= wake_id_in;
         hold_ff    <= hold_wide[rmfh_pkg::HOLD_W-1:0];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.error_code = err_ff;
   assign rsp_ch.wake_valid = wake_ff;
   assign rsp_ch.wake_id    = wake_id_ff;
   assign rsp_ch.hold_count = hold_ff;

   `RMFH_ASSERT_IMPLY(a_free_no_owner, clock, reset, nest_ff == '0, owner_ff == '0)
   `RMFH_ASSERT_IMPLY(a_waiters_held, clock, reset, !q_stat.empty, nest_ff != '0)
   `RMFH_ASSERT_NEXT(a_handover_owner, clock, reset, q_ctrl.pop,
                     owner_ff == $past(q_head_id) && nest_ff == NEST_ONE)

endmodule
